// ===== hdl/tiec_pkg.sv =====
`default_nettype none

package tiec_pkg;

  localparam int MAX_RESULTS = 16;
  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;

  // configuration register indexes
  localparam logic CFG_DEPTH = 1'b0;
  localparam logic CFG_DELAY = 1'b1;

  typedef struct packed {
    logic [63:0] start;
    logic [31:0] dur;
    logic        det;
    logic [31:0] tag;
  } entry_t;

  // search candidate handed from cell to cell
  typedef struct packed {
    logic   nxt_v;
    entry_t nxt;
    logic   prv_v;
    entry_t prv;
  } cand_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVICT,
    ST_WRITE,
    ST_SCAN,
    ST_PICK,
    ST_CHECK
  } state_t;

  // unsigned order of the key is the signed order of the time
  function automatic logic [63:0] order_key(logic [63:0] v);
    return v ^ SIGN_BIT;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tiec_cell.sv =====
`default_nettype none

module tiec_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            kill,
  input  wire logic            store_all,
  input  wire logic            store_here,
  input  wire tiec_pkg::entry_t wdata,
  input  wire logic [63:0]     bound,
  input  wire logic            strict,
  input  wire tiec_pkg::cand_t cin,
  output tiec_pkg::cand_t      cout
);
  import tiec_pkg::*;

  entry_t      ent;
  logic        live;
  logic [63:0] key;
  logic        take_n;
  logic        take_p;
  cand_t       cand_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (kill) begin
      live <= 1'b0;
    end else if (store_here) begin
      live <= 1'b1;
    end else if (store_all && live && ent.start == wdata.start) begin
      // newer entry with the same start time takes over the index
      live <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (store_here) begin
      ent <= wdata;
    end
  end

  assign key = order_key(ent.start);

  always_comb begin
    take_n = live && (key > bound || (!strict && key == bound)) &&
             (!cin.nxt_v || key < order_key(cin.nxt.start));
    take_p = live && key < bound &&
             (!cin.prv_v || key > order_key(cin.prv.start));
    cand_next = cin;
    if (take_n) begin
      cand_next.nxt_v = 1'b1;
      cand_next.nxt   = ent;
    end
    if (take_p) begin
      cand_next.prv_v = 1'b1;
      cand_next.prv   = ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cout <= '0;
    end else begin
      cout <= cand_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tiec_chain.sv =====
`default_nettype none

module tiec_chain #(
  parameter  int CAPACITY = 16,
  localparam int SLOT_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              kill,
  input  wire logic              store,
  input  wire logic [SLOT_W-1:0] slot,
  input  wire tiec_pkg::entry_t  wdata,
  input  wire logic [63:0]       bound,
  input  wire logic              strict,
  output tiec_pkg::cand_t        cout
);
  import tiec_pkg::*;

  cand_t link [CAPACITY+1];

  assign link[0] = '0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic sel;
    assign sel = (slot == SLOT_W'(k));
    tiec_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .kill      (kill && sel),
      .store_all (store),
      .store_here(store && sel),
      .wdata     (wdata),
      .bound     (bound),
      .strict    (strict),
      .cin       (link[k]),
      .cout      (link[k+1])
    );
  end

  assign cout = link[CAPACITY];

endmodule

`default_nettype wire

// ===== hdl/time_indexed_entry_cache_unit.sv =====
// Per-channel cache of timed entries with range queries in start-time order.
// Request channel (req_valid / req_stall): kind 0 inserts an entry into the
// addressed channel, kind 1 runs a range query. Every query gives one or more
// response transactions (rsp_valid / rsp_stall); last marks the final one, and
// an empty answer is a single transaction with hit low.
// Each channel is a row of CAPACITY cells; a search candidate moves one cell
// per cycle, and a search pass ends with the capture at the end of the row.
// Insert: the oldest entries are evicted one by one until there is room, then
// the entry is written. Query: one search pass finds the first result and each
// result needs one more pass for its successor; an absent channel has no search.
// req_stall is high while an item is in work. A finished response sits in the
// output register while the next item is accepted; a stalled receiver holds
// the sequencer only when another response is ready to be loaded.
// Configuration (cfg_valid / cfg_ready, always ready): index 0 cache_depth,
// index 1 allowed_delay_us; write only while no item is in work.
// Reset (synchronous, rst high) empties every channel, sets cache_depth to 16
// and allowed_delay_us to 0.
`default_nettype none

module time_indexed_entry_cache_unit #(
  parameter int CAPACITY = 16,
  parameter int CHANNELS = 4
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               req_valid,
  output logic                    req_stall,
  input  wire logic               kind,
  input  wire logic [1:0]         channel,
  input  wire logic signed [63:0] entry_time,
  input  wire logic [31:0]        entry_duration,
  input  wire logic               is_detection,
  input  wire logic [31:0]        entry_tag,
  input  wire logic signed [63:0] start_time,
  input  wire logic signed [63:0] end_time,
  input  wire logic signed [5:0]  max_count,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output logic                    hit,
  output logic [31:0]             item_tag,
  output logic signed [63:0]      item_time,
  output logic [31:0]             item_duration,
  output logic                    last
);
  import tiec_pkg::*;

  localparam int SLOT_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W = $clog2(CAPACITY + 1);
  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int N_W    = $clog2(MAX_RESULTS + 1);

  state_t state, state_next;

  logic [4:0]  cache_depth;
  logic [31:0] allowed_delay_us;

  logic [SLOT_W-1:0] oldest [CHANNELS];
  logic [FILL_W-1:0] fill   [CHANNELS];

  logic [CH_W-1:0]   ch_q;
  entry_t            wdata_q;
  logic [63:0]       start_q;
  logic [63:0]       kend_q;
  logic [5:0]        left;
  logic              unlimited;
  logic [N_W-1:0]    qn;
  logic [FILL_W-1:0] cnt;
  logic              first_scan;
  logic [63:0]       bound;
  logic              strict;
  entry_t            cur;
  logic              cur_v;
  entry_t            prv_q;
  logic              prv_v;
  entry_t            pend;
  logic              pend_v;

  cand_t cand [CHANNELS];
  cand_t chain_out;

  logic              accept;
  logic              ch_ok;
  logic [FILL_W-1:0] depth_use;
  logic [FILL_W-1:0] fill_c;
  logic [SLOT_W-1:0] oldest_c;
  logic [SLOT_W-1:0] oldest_inc;
  logic [FILL_W:0]   pos_sum;
  logic [SLOT_W-1:0] pos;
  logic              evict;
  logic              scan_done;
  logic [32:0]       span;
  logic [63:0]       diff;
  logic              covered;
  logic              exact;
  logic              cont;
  logic              out_free;
  logic              check_go;
  logic              out_load;
  logic              kill;
  logic              store;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cache_depth      <= 5'd16;
      allowed_delay_us <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DEPTH: cache_depth      <= cfg_data[4:0];
        CFG_DELAY: allowed_delay_us <= cfg_data;
        default:   cache_depth      <= cache_depth;
      endcase
    end
  end

  always_comb begin
    if (cache_depth == 5'd0) begin
      depth_use = FILL_W'(1);
    end else if (int'(cache_depth) > CAPACITY) begin
      depth_use = FILL_W'(CAPACITY);
    end else begin
      depth_use = FILL_W'(cache_depth);
    end
  end

  assign ch_ok      = int'(channel) < CHANNELS;
  assign fill_c     = fill[ch_q];
  assign oldest_c   = oldest[ch_q];
  assign oldest_inc = (oldest_c == SLOT_W'(CAPACITY - 1)) ? '0 : oldest_c + 1'b1;
  assign pos_sum    = (FILL_W+1)'(oldest_c) + (FILL_W+1)'(fill_c);
  assign pos        = (pos_sum >= (FILL_W+1)'(CAPACITY)) ?
                      SLOT_W'(pos_sum - (FILL_W+1)'(CAPACITY)) : SLOT_W'(pos_sum);
  assign evict      = (fill_c != '0) && (fill_c >= depth_use);
  assign scan_done  = (cnt == FILL_W'(CAPACITY));
  assign chain_out  = cand[ch_q];

  // coverage of the predecessor entry; its key is below the start key
  assign span    = {1'b0, prv_q.dur} + (prv_q.det ? {1'b0, allowed_delay_us} : 33'd0);
  assign diff    = order_key(start_q) - order_key(prv_q.start);
  assign covered = (span == '0) ? (diff == '0) : (diff < {31'b0, span});
  assign exact   = cur_v && (cur.start == start_q);

  assign cont = cur_v && (unlimited || left != '0) && (qn != N_W'(MAX_RESULTS)) &&
                ($signed(cur.start) < $signed(kend_q));
  assign out_free = !rsp_valid || !rsp_stall;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (kind == 1'b0) begin
            state_next = ch_ok ? ST_EVICT : ST_IDLE;
          end else begin
            state_next = ch_ok ? ST_SCAN : ST_CHECK;
          end
        end
      end
      ST_EVICT: begin
        if (!evict) begin
          state_next = ST_WRITE;
        end
      end
      ST_WRITE: state_next = ST_IDLE;
      ST_SCAN: begin
        if (scan_done) begin
          state_next = first_scan ? ST_PICK : ST_CHECK;
        end
      end
      ST_PICK: state_next = ST_CHECK;
      ST_CHECK: begin
        if (check_go) begin
          state_next = cont ? ST_SCAN : ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    req_stall = (state != ST_IDLE);
    accept    = req_valid && !req_stall;
    kill      = (state == ST_EVICT) && evict;
    store     = (state == ST_WRITE);
    check_go  = (state == ST_CHECK) && (out_free || (cont && !pend_v));
    out_load  = check_go && (pend_v || !cont);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CHANNELS; c++) begin
        oldest[c] <= '0;
        fill[c]   <= '0;
      end
    end else if (kill) begin
      oldest[ch_q] <= oldest_inc;
      fill[ch_q]   <= fill_c - 1'b1;
    end else if (store) begin
      fill[ch_q] <= fill_c + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_v <= 1'b0;
      cur_v  <= 1'b0;
      prv_v  <= 1'b0;
      cnt    <= '0;
    end else begin
      if (accept) begin
        ch_q          <= CH_W'(channel);
        wdata_q.start <= entry_time;
        wdata_q.dur   <= entry_duration;
        wdata_q.det   <= is_detection;
        wdata_q.tag   <= entry_tag;
        start_q       <= start_time;
        kend_q        <= end_time;
        left          <= max_count;
        unlimited     <= max_count[5];
        qn            <= '0;
        pend_v        <= 1'b0;
        cur_v         <= 1'b0;
        bound         <= order_key(start_time);
        strict        <= 1'b0;
        first_scan    <= 1'b1;
        cnt           <= '0;
      end
      if (state == ST_SCAN) begin
        cnt <= cnt + 1'b1;
        if (scan_done) begin
          cur   <= chain_out.nxt;
          cur_v <= chain_out.nxt_v;
          prv_q <= chain_out.prv;
          prv_v <= chain_out.prv_v;
        end
      end
      if (state == ST_PICK) begin
        first_scan <= 1'b0;
        if (!exact && prv_v && covered) begin
          cur   <= prv_q;
          cur_v <= 1'b1;
        end
      end
      if (check_go && cont) begin
        // hold the entry until its successor tells whether it is the last one
        pend   <= cur;
        pend_v <= 1'b1;
        qn     <= qn + 1'b1;
        if (!unlimited) begin
          left <= left - 1'b1;
        end
        bound  <= order_key(cur.start);
        strict <= 1'b1;
        cnt    <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      hit           <= pend_v;
      item_tag      <= pend_v ? pend.tag : '0;
      item_time     <= pend_v ? $signed(pend.start) : '0;
      item_duration <= pend_v ? pend.dur : '0;
      last          <= !cont;
    end
  end

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic sel;
    assign sel = (ch_q == CH_W'(c));
    tiec_chain #(
      .CAPACITY(CAPACITY)
    ) u_chain (
      .clk   (clk),
      .rst   (rst),
      .kill  (kill && sel),
      .store (store && sel),
      .slot  (kill ? oldest_c : pos),
      .wdata (wdata_q),
      .bound (bound),
      .strict(strict),
      .cout  (cand[c])
    );
  end

`ifndef SYNTHESIS
  a_qn_bound: assert property (@(posedge clk) disable iff (rst)
    qn <= N_W'(MAX_RESULTS))
    else $error("result count above limit");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WRITE) |-> (fill_c < depth_use))
    else $error("insert without free slot");

  a_bound_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && $past(state) == ST_SCAN) |-> $stable(bound))
    else $error("search bound moved during pass");

  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    (out_load && !pend_v) |-> !cont)
    else $error("empty answer that is not final");

  a_idle_out: assert property (@(posedge clk) disable iff (rst)
    (state != ST_CHECK) |-> !out_load)
    else $error("response loaded outside check");
`endif

endmodule

`default_nettype wire
